// ----- src/sbcs_pkg.sv -----
// Package for the shared-bus carrier-sense model: sizes, item structs,
// event table entry type, state and code enums, saturating reach add.
// No dependencies.
package sbcs_pkg;

    localparam int MAX_EVENTS = 16;
    localparam int REACH_BITS = 20;

    localparam int IDX_W      = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
    localparam int NODE_W     = 6;
    localparam int NODE_CNT_W = 7;
    localparam int STEP_W     = 16;
    localparam int METER_FX_W = 12;
    // ten meters per node, 8 fraction bits
    localparam logic [METER_FX_W-1:0] METERS_PER_NODE_FX = 12'd2560;
    localparam int CABLE_W    = NODE_CNT_W + METER_FX_W;
    localparam int DIST_W     = NODE_W + METER_FX_W;
    localparam int CMP_W      = (REACH_BITS > CABLE_W) ? REACH_BITS : CABLE_W;
    localparam int SUM_W      = ((REACH_BITS > STEP_W) ? REACH_BITS : STEP_W) + 1;

    localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 7'd4;
    localparam logic [STEP_W-1:0]     REACH_STEP_RST = 16'd512;

    localparam int PADDR_W = 3;
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_REACH_STEP = 1'b1;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_TX    = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_SENDING = 2'd0,
        PH_LAPSED  = 2'd1,
        PH_ENDED   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]        kind;
        logic [NODE_W-1:0] node;
    } t_in_item;

    typedef struct packed {
        logic busy_res;
        logic dropped;
    } t_out_item;

    typedef struct packed {
        logic [1:0]            phase;
        logic [NODE_W-1:0]     source;
        logic [REACH_BITS-1:0] on_reach;
        logic [REACH_BITS-1:0] off_reach;
    } t_slot;

    function automatic logic [REACH_BITS-1:0] sat_add(
        input logic [REACH_BITS-1:0] a,
        input logic [STEP_W-1:0]     b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s[SUM_W-1:REACH_BITS] != '0) begin
            return '1;
        end
        return s[REACH_BITS-1:0];
    endfunction

endpackage

// ----- src/shared_bus_carrier_sense_model_top.sv -----
// Top level of the shared-bus carrier-sense model: APB register port,
// event table memory and the per-item scan sequencer. Uses sbcs_pkg.
//
// Each accepted beat (tick, transmit, busy query or none) walks the used part of
// the event table once through a single-port-read memory with a registered
// read port, one slot per cycle, then passes a finish state that waits for
// room in the output register. Where count is the number of live events (up to
// 16 with a full table), used events
// always sit in slots 0..count-1, so a fill count replaces per-slot valid
// bits and no clearing pass is needed after reset. A tick compacts the
// table in place: each kept event is written back at or below the slot
// being read, so a write never hits a slot that is still to be read.
// A result waits in an output register; the next beat is taken meanwhile.
module shared_bus_carrier_sense_model_top
    import sbcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_state                r_state, n_state;
    logic [1:0]            r_kind, n_kind;
    logic [NODE_W-1:0]     r_node, n_node;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_issue, n_issue;
    logic [CNT_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic                  r_pend, n_pend;
    logic [IDX_W-1:0]      r_pend_idx, n_pend_idx;
    logic                  r_found, n_found;
    logic                  r_busy, n_busy;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out_data, n_out_data;
    logic [NODE_CNT_W-1:0] r_node_count;
    logic [STEP_W-1:0]     r_reach_step;

    t_slot                 r_mem [MAX_EVENTS];
    t_slot                 r_rdata;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    t_slot                 mem_wd;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_ra;

    logic                  cfg_we;
    logic [CABLE_W-1:0]    cable;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_reach_step <= REACH_STEP_RST;
        end else if (cfg_we) begin
            if (paddr[2] == REG_NODE_COUNT) begin
                r_node_count <= pwdata[NODE_CNT_W-1:0];
            end else begin
                r_reach_step <= pwdata[STEP_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_REACH_STEP) begin
            prdata = 32'(r_reach_step);
        end else begin
            prdata = 32'(r_node_count);
        end
    end

    assign cable = CABLE_W'(r_node_count) * CABLE_W'(METERS_PER_NODE_FX);

    // ---------------- event table ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_wr_ptr    <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_wr_ptr    <= n_wr_ptr;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_kind     <= n_kind;
        r_node     <= n_node;
        r_pend_idx <= n_pend_idx;
        r_out_data <= n_out_data;
    end

    always_comb begin
        t_slot             upd;
        logic [1:0]        ph;
        logic [NODE_W-1:0] gap;
        logic [DIST_W-1:0] reach_need;
        logic              out_free;

        n_state     = r_state;
        n_kind      = r_kind;
        n_node      = r_node;
        n_count     = r_count;
        n_issue     = r_issue;
        n_wr_ptr    = r_wr_ptr;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_found     = r_found;
        n_busy      = r_busy;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = r_rdata;
        mem_re      = 1'b0;
        mem_ra      = r_issue[IDX_W-1:0];
        out_free    = !r_out_valid || i_out_ready;

        upd = r_rdata;
        ph  = r_rdata.phase;
        unique case (r_rdata.phase)
            PH_LAPSED:  ph = PH_ENDED;
            PH_SENDING: ph = PH_LAPSED;
            default:    ph = r_rdata.phase;
        endcase
        upd.phase    = ph;
        upd.on_reach = sat_add(r_rdata.on_reach, r_reach_step);
        if (ph == PH_ENDED) begin
            upd.off_reach = sat_add(r_rdata.off_reach, r_reach_step);
        end

        gap  = (r_node >= r_rdata.source) ? (r_node - r_rdata.source)
                                          : (r_rdata.source - r_node);
        reach_need = DIST_W'(gap) * DIST_W'(METERS_PER_NODE_FX);

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_kind   = i_in_data.kind;
                    n_node   = i_in_data.node;
                    n_issue  = '0;
                    n_wr_ptr = '0;
                    n_found  = 1'b0;
                    n_busy   = 1'b0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_issue < r_count) begin
                    mem_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue[IDX_W-1:0];
                    n_issue    = r_issue + 1'b1;
                end else begin
                    // last read data is consumed in this cycle
                    n_state = ST_FINISH;
                end
                if (r_pend) begin
                    unique case (r_kind)
                        KIND_TICK: begin
                            if (!(CMP_W'(r_rdata.off_reach) > CMP_W'(cable))) begin
                                mem_we   = 1'b1;
                                mem_wa   = r_wr_ptr[IDX_W-1:0];
                                mem_wd   = upd;
                                n_wr_ptr = r_wr_ptr + 1'b1;
                            end
                        end
                        KIND_TX: begin
                            if (!r_found && r_rdata.source == r_node &&
                                r_rdata.phase == PH_LAPSED) begin
                                mem_we       = 1'b1;
                                mem_wa       = r_pend_idx;
                                mem_wd.phase = PH_SENDING;
                                n_found      = 1'b1;
                            end
                        end
                        KIND_QUERY: begin
                            if (CMP_W'(r_rdata.on_reach) >= CMP_W'(reach_need) &&
                                CMP_W'(r_rdata.off_reach) < CMP_W'(reach_need)) begin
                                n_busy = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out_data.busy_res = (r_kind == KIND_QUERY) && r_busy;
                    n_out_data.dropped  = 1'b0;
                    n_state             = ST_IDLE;
                    if (r_kind == KIND_TICK) begin
                        n_count = r_wr_ptr;
                    end else if (r_kind == KIND_TX && !r_found) begin
                        if (r_count == CNT_W'(MAX_EVENTS)) begin
                            n_out_data.dropped = 1'b1;
                        end else begin
                            mem_we           = 1'b1;
                            mem_wa           = r_count[IDX_W-1:0];
                            mem_wd.phase     = PH_SENDING;
                            mem_wd.source    = r_node;
                            mem_wd.on_reach  = '0;
                            mem_wd.off_reach = '0;
                            n_count          = r_count + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_EVENTS))
        else $error("event count beyond table size");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_wr_ptr <= r_issue)
        else $error("compaction write pointer ahead of read pointer");

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_state == ST_SCAN)
        else $error("read data pending outside scan");

    a_count_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != $past(r_count) |-> $past(r_state) == ST_FINISH)
        else $error("event count changed outside finish");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FINISH)
        else $error("result raised without a finished item");

endmodule

// ----- dv/shared_bus_carrier_sense_model_top_tb.sv -----
// Self-checking testbench for shared_bus_carrier_sense_model_top: drives tick, transmit
// and busy-query beats and checks every result against a cable model of its own.
// Depends on sbcs_pkg and the top level; standalone otherwise.
module shared_bus_carrier_sense_model_top_tb;
    import sbcs_pkg::*;

    localparam int DRAIN_CYCLES = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // cable model state
    t_slot                 bus_events [MAX_EVENTS];
    int                    live_events = 0;
    logic [NODE_CNT_W-1:0] cfg_node_count = NODE_COUNT_RST;
    logic [STEP_W-1:0]     cfg_reach_step = REACH_STEP_RST;
    t_out_item             sense_q [$];

    int               error_count = 0;
    int               items_accepted = 0;
    int               results_seen = 0;
    int               busy_seen = 0;
    int               drops_seen = 0;
    int               settings_used = 0;
    int               in_idle_pct = 0;
    int               out_stall_pct = 0;
    logic [NODE_W-1:0] talker = '0;
    t_out_item        want;

    shared_bus_carrier_sense_model_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Timeout: run did not finish");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [REACH_BITS-1:0] advance_front(input logic [REACH_BITS-1:0] r);
        logic [REACH_BITS:0] s;
        s = {1'b0, r} + (REACH_BITS + 1)'(cfg_reach_step);
        if (s[REACH_BITS]) begin
            return '1;
        end
        return s[REACH_BITS-1:0];
    endfunction

    // Applies one beat to the cable model and returns the flags it should produce.
    function automatic t_out_item sense_bus(input t_in_item item);
        t_out_item             res;
        logic [CABLE_W-1:0]    cable;
        logic [DIST_W-1:0]     reach_need;
        logic [NODE_W-1:0]     gap;
        t_slot                 ev;
        int                    kept;
        int                    i;
        bit                    renewed;
        res = '0;
        case (item.kind)
            KIND_TICK: begin
                cable = CABLE_W'(cfg_node_count) * CABLE_W'(METERS_PER_NODE_FX);
                kept = 0;
                for (i = 0; i < live_events; i++) begin
                    ev = bus_events[i];
                    if (ev.off_reach <= cable) begin
                        if (ev.phase == PH_LAPSED) begin
                            ev.phase = PH_ENDED;
                        end else if (ev.phase == PH_SENDING) begin
                            ev.phase = PH_LAPSED;
                        end
                        if (ev.phase == PH_ENDED) begin
                            ev.off_reach = advance_front(ev.off_reach);
                        end
                        ev.on_reach = advance_front(ev.on_reach);
                        bus_events[kept] = ev;
                        kept++;
                    end
                end
                live_events = kept;
            end
            KIND_TX: begin
                renewed = 1'b0;
                for (i = 0; i < live_events && !renewed; i++) begin
                    if (bus_events[i].source == item.node && bus_events[i].phase == PH_LAPSED) begin
                        bus_events[i].phase = PH_SENDING;
                        renewed = 1'b1;
                    end
                end
                if (!renewed) begin
                    if (live_events == MAX_EVENTS) begin
                        res.dropped = 1'b1;
                    end else begin
                        ev.phase = PH_SENDING;
                        ev.source = item.node;
                        ev.on_reach = '0;
                        ev.off_reach = '0;
                        bus_events[live_events] = ev;
                        live_events++;
                    end
                end
            end
            KIND_QUERY: begin
                for (i = 0; i < live_events; i++) begin
                    ev = bus_events[i];
                    gap = (item.node >= ev.source) ? item.node - ev.source : ev.source - item.node;
                    reach_need = DIST_W'(gap) * DIST_W'(METERS_PER_NODE_FX);
                    if (ev.on_reach >= reach_need && ev.off_reach < reach_need) begin
                        res.busy_res = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_in_item make_item(input t_kind k, input logic [NODE_W-1:0] n);
        t_in_item it;
        it.kind = k;
        it.node = n;
        return it;
    endfunction

    // mostly nodes on the cable, sometimes anywhere in the field
    function automatic logic [NODE_W-1:0] pick_node();
        int lim;
        lim = (cfg_node_count == 0) ? 1 : ((cfg_node_count > 64) ? 64 : int'(cfg_node_count));
        if ($urandom_range(0, 99) < 85) begin
            return NODE_W'($urandom_range(0, lim - 1));
        end
        return NODE_W'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    // Valid stays high on return so back-to-back beats need no extra toggle.
    task automatic push_item(input t_in_item item);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sense_q.insert(sense_q.size(), sense_bus(item));
        if (item.kind != KIND_NONE) begin
            items_accepted++;
        end
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            busy_seen += o_out_data.busy_res;
            drops_seen += o_out_data.dropped;
            if (sense_q.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want = sense_q.pop_front();
                if (o_out_data.busy_res !== want.busy_res) begin
                    report_mismatch($sformatf("busy_res got %b want %b",
                                              o_out_data.busy_res, want.busy_res));
                end
                if (o_out_data.dropped !== want.dropped) begin
                    report_mismatch($sformatf("dropped got %b want %b",
                                              o_out_data.dropped, want.dropped));
                end
            end
        end
    end

    // Drops valid, waits for all pending results, then lets the block go quiet.
    task automatic wait_idle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (sense_q.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        if (sense_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", sense_q.size()));
            sense_q.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'({reg_sel, 2'b00});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        if (reg_sel == REG_NODE_COUNT) begin
            cfg_node_count = value[NODE_CNT_W-1:0];
        end else begin
            cfg_reach_step = value[STEP_W-1:0];
        end
    endtask

    task automatic apply_setting(input logic [NODE_CNT_W-1:0] nc, input logic [STEP_W-1:0] step);
        wait_idle();
        write_reg(REG_NODE_COUNT, 32'(nc));
        write_reg(REG_REACH_STEP, 32'(step));
        settings_used++;
    endtask

    task automatic set_idling(input int in_pct, input int out_pct);
        in_idle_pct = in_pct;
        out_stall_pct = out_pct;
    endtask

    // Empty table, own signal, node past the cable end, renewal, fronts passing nodes.
    task automatic test_basic_cases();
        apply_setting(7'd3, 16'd2560);
        push_item(make_item(KIND_NONE, 6'd63));
        push_item(make_item(KIND_QUERY, 6'd0));
        push_item(make_item(KIND_TX, 6'd0));
        push_item(make_item(KIND_TX, 6'd63));
        push_item(make_item(KIND_QUERY, 6'd63));
        push_item(make_item(KIND_TICK, 6'd0));
        push_item(make_item(KIND_QUERY, 6'd1));
        push_item(make_item(KIND_QUERY, 6'd0));
        push_item(make_item(KIND_TX, 6'd0));
        push_item(make_item(KIND_TICK, 6'd63));
        push_item(make_item(KIND_TICK, 6'd21));
        push_item(make_item(KIND_QUERY, 6'd2));
        push_item(make_item(KIND_QUERY, 6'd1));
        repeat (3) push_item(make_item(KIND_TICK, 6'd42));
        push_item(make_item(KIND_QUERY, 6'd1));
        push_item(make_item(KIND_QUERY, 6'd62));
    endtask

    // Fill every slot, overflow once, then renew a lapsed event while full.
    task automatic test_full_table();
        apply_setting(7'd5, 16'd1);
        while (live_events < MAX_EVENTS) begin
            push_item(make_item(KIND_TX, NODE_W'(live_events * 4 + 3)));
        end
        push_item(make_item(KIND_TX, 6'd63));
        push_item(make_item(KIND_TICK, 6'd0));
        push_item(make_item(KIND_TX, 6'd3));
        push_item(make_item(KIND_QUERY, 6'd3));
    endtask

    task automatic test_random_traffic(input logic [NODE_CNT_W-1:0] nc,
                                       input logic [STEP_W-1:0] step, input int n);
        int start;
        int pick;
        int cnt;
        apply_setting(nc, step);
        start = items_accepted;
        talker = pick_node();
        while (items_accepted - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // one bus round: a few senders, a tick, a few listeners
                cnt = $urandom_range(0, 3);
                repeat (cnt) push_item(make_item(KIND_TX,
                                       $urandom_range(0, 1) ? talker : pick_node()));
                push_item(make_item(KIND_TICK, NODE_W'($urandom)));
                cnt = $urandom_range(0, 3);
                repeat (cnt) push_item(make_item(KIND_QUERY, pick_node()));
                if ($urandom_range(0, 15) == 0) begin
                    talker = pick_node();
                end
            end else if (pick < 80) begin
                repeat (MAX_EVENTS + 2) push_item(make_item(KIND_TX, pick_node()));
            end else begin
                repeat (4) push_item(make_item(t_kind'($urandom_range(0, 3)), NODE_W'($urandom)));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_EVENTS; i++) begin
            bus_events[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_idling(19, 59);
        test_basic_cases();
        test_full_table();
        test_random_traffic(7'd4, 16'd512, 300);
        test_random_traffic(7'd64, 16'd65535, 300);

        set_idling(59, 19);
        test_random_traffic(7'd1, 16'd1, 300);
        test_random_traffic(7'd0, 16'd2560, 250);

        set_idling(0, 0);
        test_random_traffic(7'd127, 16'd3000, 300);
        test_random_traffic(7'd16, 16'd700, 300);
        test_random_traffic(7'd2, 16'd0, 200);
        wait_idle();

        $display("Sent %0d beats over %0d register settings; %0d results checked",
                 items_accepted, settings_used, results_seen);
        $display("Busy answers seen: %0d, transmits dropped on a full table: %0d",
                 busy_seen, drops_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- shared_bus_carrier_sense_model_top.f -----
src/sbcs_pkg.sv
src/shared_bus_carrier_sense_model_top.sv
dv/shared_bus_carrier_sense_model_top_tb.sv
